FILE: src/modular_exponentiation_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation unit
// Shared forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next, outside reset.
`define MX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define MX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, checked during reset too.
`define MX_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and the status type of the modular multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package modexp_pkg;

  localparam int DEFAULT_WIDTH = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } mulmod_status_t;

endpackage

FILE: src/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base to the power exponent modulo a configured modulus.
// ----------------------------------------------------------------------------
// The input channel takes an item of base and exponent when in_valid and
// in_ready are both high; the output channel delivers result when out_valid
// and out_ready are both high. The modulus is written through cfg_we and
// cfg_wdata and resets to one. The user is bound to write it only while the
// unit is idle; the unit itself does not enforce this. The exponent is
// scanned from its least significant bit. The base is first reduced by one
// modular multiplication, then each set bit costs one multiplication into
// the accumulator and each bit below the top one costs a squaring. Every
// multiplication runs on one shared shift-and-add unit at one bit per cycle.
// A zero exponent or a modulus of one skips the multiplications. The unit
// takes no new item while busy. The result sits in an output register, so a
// new item is taken while an earlier result waits; if the receiver stalls, a
// finished item waits before that register. Reset empties the output and
// returns the unit to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_unit #(
  parameter int WIDTH = modexp_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] base,
  input  logic [WIDTH-1:0] exponent,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] result
);
  import modexp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PREP     = 3'd1;
  localparam logic [2:0] S_RED_WAIT = 3'd2;
  localparam logic [2:0] S_STEP     = 3'd3;
  localparam logic [2:0] S_MUL_WAIT = 3'd4;
  localparam logic [2:0] S_SQ_GO    = 3'd5;
  localparam logic [2:0] S_SQ_WAIT  = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  logic [2:0]       state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] b_val;
  logic [WIDTH-1:0] e_val;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] fin_val;

  logic             mul_start;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_prod;
  mulmod_status_t   mul_status;
  logic             out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = b_val;
    unique case (state)
      S_PREP: begin
        mul_start = !mul_status.busy;
        mul_a     = ONE;
      end
      S_STEP: begin
        mul_start = !mul_status.busy;
        mul_a     = e_val[0] ? acc : b_val;
      end
      S_SQ_GO: begin
        mul_start = !mul_status.busy;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  modexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (b_val),
    .m       (modulus),
    .product (mul_prod),
    .status  (mul_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      modulus <= ONE;
    end else begin
      if (cfg_we) begin
        modulus <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            b_val <= base;
            e_val <= exponent;
            acc   <= ONE;
            if (exponent == '0) begin
              fin_val <= ONE;
              state   <= S_FINISH;
            end else if (modulus == ONE) begin
              fin_val <= '0;
              state   <= S_FINISH;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state <= S_RED_WAIT;
        end
        S_RED_WAIT: begin
          if (mul_status.done) begin
            b_val <= mul_prod;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          state <= e_val[0] ? S_MUL_WAIT : S_SQ_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_status.done) begin
            acc <= mul_prod;
            if (e_val[WIDTH-1:1] == '0) begin
              fin_val <= mul_prod;
              state   <= S_FINISH;
            end else begin
              state <= S_SQ_GO;
            end
          end
        end
        S_SQ_GO: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (mul_status.done) begin
            b_val <= mul_prod;
            e_val <= {1'b0, e_val[WIDTH-1:1]};
            state <= S_STEP;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= fin_val;
    end
  end

endmodule

FILE: src/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes (a * b) mod m by shift-and-add, one bit of b per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modexp_mulmod #(
  parameter int WIDTH = modexp_pkg::DEFAULT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [WIDTH-1:0]            a,
  input  logic [WIDTH-1:0]            b,
  input  logic [WIDTH-1:0]            m,
  output logic [WIDTH-1:0]            product,
  output modexp_pkg::mulmod_status_t  status
);
  import modexp_pkg::*;

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

  // Sum modulo m for x < m and y < m; a zero modulus wraps at the word width.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] md);
    logic [WIDTH-1:0] gap;
    gap = md - y;
    if (x >= gap) begin
      return x - gap;
    end
    return x + y;
  endfunction

  logic [WIDTH-1:0] a_val;
  logic [WIDTH-1:0] b_val;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] r_dbl;
  logic [WIDTH-1:0] r_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  always_comb begin
    r_dbl  = add_mod(r, r, m);
    r_next = b_val[WIDTH-1] ? add_mod(r_dbl, a_val, m) : r_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        a_val <= a;
        b_val <= b;
        r     <= '0;
        cnt   <= LAST;
        busy  <= 1'b1;
      end else if (busy) begin
        r     <= r_next;
        b_val <= {b_val[WIDTH-2:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign product     = r;
  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: src/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Concurrent checks on the top level's channels, bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modular_exponentiation_unit_macros.svh"

module modexp_checker #(
  parameter int WIDTH = modexp_pkg::DEFAULT_WIDTH
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [WIDTH-1:0] base,
  input logic [WIDTH-1:0] exponent,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] result
);
  import modexp_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  `MX_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result), "result changed while stalled")
  `MX_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(base) && $stable(exponent), "input item changed while waiting")
  `MX_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, !in_ready, "item accepted while a previous item is still in work")
  `MX_ASSERT_SAME(a_result_after_work, clk, rst, $rose(out_valid), !$past(in_ready), "result appeared without a finished item")
  `MX_ASSERT_NEXT_ALWAYS(a_reset_state, clk, rst, !out_valid && in_ready, "reset did not return the unit to idle")

endmodule

bind modular_exponentiation_unit modexp_checker #(.WIDTH(WIDTH)) u_modexp_checker (.*);

FILE: test/tb_modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the modular exponentiation unit
// Drives base and exponent items through the unit under several modulus
// settings with random idle gaps on both channels. A scoreboard predicts
// each power and compares it with the result stream in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class modexp_scoreboard;
  typedef struct {
    bit [31:0] base;
    bit [31:0] exponent;
    bit [31:0] modulus;
    bit [31:0] power;
  } power_entry_t;

  bit [31:0]    modulus;
  power_entry_t power_q[$];
  int           checked;
  int           mismatches;

  function new();
    modulus    = 32'd1;
    checked    = 0;
    mismatches = 0;
  endfunction

  function void set_modulus(bit [31:0] m);
    modulus = m;
  endfunction

  function bit [31:0] mul_reduce(bit [31:0] a, bit [31:0] b);
    bit [63:0] prod;
    bit [63:0] rem;
    prod = {32'd0, a} * {32'd0, b};
    if (modulus == 32'd0) begin
      return prod[31:0];
    end
    rem = prod % {32'd0, modulus};
    return rem[31:0];
  endfunction

  function bit [31:0] power_mod(bit [31:0] b_in, bit [31:0] e_in);
    bit [31:0] b;
    bit [31:0] e;
    bit [31:0] acc;
    if (e_in == 32'd0) begin
      return 32'd1;
    end
    b = b_in;
    if (modulus != 32'd0) begin
      b = b_in % modulus;
    end
    acc = (modulus == 32'd1) ? 32'd0 : 32'd1;
    e = e_in;
    while (e != 32'd0) begin
      if (e[0]) begin
        acc = mul_reduce(acc, b);
      end
      b = mul_reduce(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  function void note_item(bit [31:0] b, bit [31:0] e);
    power_entry_t ent;
    ent.base     = b;
    ent.exponent = e;
    ent.modulus  = modulus;
    ent.power    = power_mod(b, e);
    power_q.push_back(ent);
  endfunction

  function void check_result(bit [31:0] actual);
    power_entry_t ent;
    if (power_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result item %h with no item outstanding", actual);
      end
      return;
    end
    ent = power_q.pop_front();
    checked++;
    if (actual !== ent.power) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Result mismatch: base %h exponent %h modulus %h expected %h got %h",
                 ent.base, ent.exponent, ent.modulus, ent.power, actual);
      end
    end
  endfunction

  function int pending();
    return power_q.size();
  endfunction
endclass

module tb_modular_exponentiation_unit;
  localparam int W           = modexp_pkg::DEFAULT_WIDTH;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [W-1:0] cfg_wdata;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] base;
  logic [W-1:0] exponent;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] result;

  modexp_scoreboard board;
  bit               calm;
  int               items_sent;
  int               settings_used;
  int               hold;
  longint           cycle_count;

  modular_exponentiation_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .base     (base),
    .exponent (exponent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result   (result)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 80);
  endfunction

  function automatic bit [31:0] random_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return $urandom();
    end else if (r < 50) begin
      return $urandom_range(0, 15);
    end else if (r < 65) begin
      return board.modulus + $urandom_range(0, 2) - 32'd1;
    end else if (r < 75) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom() & ($urandom() | 32'h0000_FFFF);
  endfunction

  function automatic bit [31:0] random_exponent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 32'd0;
    end else if (r < 15) begin
      return 32'hFFFF_FFFF;
    end else if (r < 20) begin
      return 32'd1;
    end else if (r < 60) begin
      return $urandom_range(2, 40);
    end
    return $urandom();
  endfunction

  task automatic send_item(input bit [31:0] b, input bit [31:0] e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (!in_ready);
    board.note_item(b, e);
    items_sent++;
  endtask

  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic write_modulus(input bit [31:0] m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_modulus(m);
    settings_used++;
  endtask

  task automatic random_phase(input bit [31:0] m, input int count, input bit quiet,
                              input bit pause_mid);
    drain_results();
    write_modulus(m);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        drain_results();
      end
      send_item(random_base(), random_exponent());
    end
    drain_results();
    calm = 1'b0;
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    base        = '0;
    exponent    = '0;
    out_ready   = 1'b0;
    calm        = 1'b0;
    items_sent  = 0;
    settings_used = 0;
    hold        = 0;
    cycle_count = 0;
    board       = new();
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        board.check_result(result);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        hold = pick_gap();
        out_ready <= (hold == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset modulus of one.
    send_item(32'd5, 32'd0);
    send_item(32'd0, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd7);
    send_item(32'd3, 32'hFFFF_FFFF);
    drain_results();

    write_modulus(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'd2);
    send_item(32'd2, 32'd31);
    send_item(32'd2, 32'd32);
    send_item(32'd12345, 32'd1);
    send_item(32'd0, 32'd5);
    send_item(32'd0, 32'd0);
    send_item(32'd7, 32'h8000_0000);
    drain_results();

    write_modulus(32'd2);
    send_item(32'd3, 32'd5);
    send_item(32'd4, 32'd1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd9, 32'd0);
    drain_results();

    write_modulus(32'd1000003);
    send_item(32'd2, 32'd1000002);
    send_item(32'd1000003, 32'd3);
    send_item(32'd1000004, 32'd2);
    drain_results();

    write_modulus(32'h8000_0000);
    send_item(32'd3, 32'hFFFF_FFFF);
    send_item(32'h8000_0001, 32'd2);

    random_phase(32'd1, 25, 1'b0, 1'b0);
    random_phase(32'd3, 30, 1'b1, 1'b0);
    random_phase(32'hFFFF_FFFF, 35, 1'b0, 1'b1);
    random_phase($urandom() | 32'h8000_0001, 35, 1'b0, 1'b0);
    random_phase($urandom_range(2, 64), 30, 1'b0, 1'b1);
    random_phase($urandom_range(2, 131071), 30, 1'b1, 1'b0);
    random_phase(32'd2, 25, 1'b0, 1'b0);
    random_phase(32'h8000_0000, 25, 1'b0, 1'b0);
    random_phase($urandom() | 32'd2, 35, 1'b0, 1'b0);

    drain_results();
    repeat (40) @(posedge clk);

    $display("Sent %0d items over %0d modulus settings; %0d results compared.",
             items_sent, settings_used + 1, board.checked);
    $display("Mismatches: %0d, items still outstanding: %0d.",
             board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/modexp_pkg.sv
src/modexp_mulmod.sv
src/modular_exponentiation_unit.sv
src/modexp_checker.sv
test/tb_modular_exponentiation_unit.sv
